>>> rtl/psd_pkg.sv
// Package with the shared types and field widths of the positive subarray sum detector.
package psd_pkg;

    // Width of one sequence element and of the target register.
    localparam int unsigned VALUE_W = 31;
    // Width of the running sum; two elements always fit.
    localparam int unsigned SUM_W   = 32;

    // Sequencer states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EVAL
    } t_state;

endpackage

>>> rtl/psd_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module psd_ram #(
    parameter int unsigned DATA_W = 31,
    parameter int unsigned DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write and read take effect at the clock edge; read data appears in the cycle after the read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/positive_subarray_sum_detector.sv
// Top level of the positive subarray sum detector: window FIFO in RAM, running sum, sequencer.
//
// The block watches a sequence of positive elements, one per input transfer, and decides
// whether some contiguous run of them sums exactly to target_sum. The sliding window of
// elements lives in a RAM of WINDOW_DEPTH entries; the oldest entry is evicted while the
// window sum plus the new element exceeds the target, or while the window is full, which
// marks an overflow. Each element is accepted, then evaluated; every eviction repeats the
// evaluate step, since it waits for a read of the window RAM, whose read data is
// registered; each element is stored and evicted at most once. An element
// marked with tlast also waits in its evaluate cycle while the previous result transfer is
// still pending. On the element marked with tlast one result transfer carries the found flag
// in tdata bit 0 and the window overflow flag in tuser, and the sequence state returns to
// empty. The window RAM needs no clearing after reset, so the block takes elements from the
// first cycle on. target_sum is written through the configuration channel, which is always
// ready; the user must write it only while the block is idle, the block does not enforce it.
module positive_subarray_sum_detector #(
    parameter int unsigned WINDOW_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel: target_sum.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data,
    // Element input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [30:0] value, [31] zero fill
    input  logic        i_s_axis_tlast,
    // Result output stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] found, [7:1] zero fill
    output logic        o_m_axis_tuser    // [0] window_overflow
);

    localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned VW = psd_pkg::VALUE_W;
    localparam int unsigned SW = psd_pkg::SUM_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW_DEPTH);

    // Control state.
    psd_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic [SW-1:0]   r_sum, n_sum;
    logic            r_found, n_found;
    logic            r_ovf, n_ovf;
    logic [VW-1:0]   r_target;
    logic            r_out_valid, n_out_valid;
    logic            r_out_found, n_out_found;
    logic            r_out_ovf, n_out_ovf;

    // Payload of the element being evaluated.
    logic [VW-1:0]   r_value;
    logic            r_last;

    // Window RAM access.
    logic            ram_we;
    logic [VW-1:0]   ram_rdata;

    logic [SW-1:0]   sum_plus_v;
    logic [SW-1:0]   target_ext;
    logic            too_big;
    logic            in_xfer;
    logic            out_room;

    assign target_ext  = {1'b0, r_target};
    assign sum_plus_v  = r_sum + {1'b0, r_value};
    assign too_big     = sum_plus_v > target_ext;
    assign in_xfer     = i_s_axis_tvalid && o_s_axis_tready;
    assign out_room    = !r_out_valid || i_m_axis_tready;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == psd_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_found};
    assign o_m_axis_tuser  = r_out_ovf;

    // Window store; the read address always follows the next head so that the oldest
    // entry is on the read data when the evaluation step needs it.
    psd_ram #(
        .DATA_W (VW),
        .DEPTH  (WINDOW_DEPTH)
    ) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (r_value),
        .i_raddr (n_head),
        .o_rdata (ram_rdata)
    );

    // Sequencer: evict, append and result decisions.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_sum       = r_sum;
        n_found     = r_found;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_found = r_out_found;
        n_out_ovf   = r_out_ovf;
        ram_we      = 1'b0;

        case (r_state)
            psd_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = psd_pkg::ST_EVAL;
                end
            end
            psd_pkg::ST_EVAL: begin
                if ((r_count != '0) && (too_big || (r_count == FULL_CNT))) begin
                    // Evict the oldest entry; a full window that must take the element
                    // marks an overflow.
                    if (!too_big) begin
                        n_ovf = 1'b1;
                    end
                    n_sum   = r_sum - {1'b0, ram_rdata};
                    n_head  = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
                    n_count = r_count - CW'(1);
                end else if (!r_last || out_room) begin
                    // Final step for this element: append it if it fits, then check for a hit.
                    if (!too_big) begin
                        ram_we  = 1'b1;
                        n_sum   = sum_plus_v;
                        n_tail  = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
                        n_count = r_count + CW'(1);
                    end
                    n_found = r_found || (n_sum == target_ext);
                    n_state = psd_pkg::ST_IDLE;
                    if (r_last) begin
                        n_out_valid = 1'b1;
                        n_out_found = n_found;
                        n_out_ovf   = r_ovf;
                        n_head      = '0;
                        n_tail      = '0;
                        n_count     = '0;
                        n_sum       = '0;
                        n_found     = 1'b0;
                        n_ovf       = 1'b0;
                    end
                end
            end
            default: begin
                n_state = psd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psd_pkg::ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_found     <= 1'b0;
            r_ovf       <= 1'b0;
            r_target    <= VW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_found     <= n_found;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_target <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out_found <= n_out_found;
        r_out_ovf   <= n_out_ovf;
        if (in_xfer) begin
            r_value <= i_s_axis_tdata[VW-1:0];
            r_last  <= i_s_axis_tlast;
        end
    end

    // The window never holds more entries than the store has.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("window count beyond store depth");

    // An empty window has a zero running sum.
    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_sum == '0))
        else $error("empty window with nonzero sum");

    // Appending an element always ends its evaluation.
    a_append_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_state == psd_pkg::ST_IDLE))
        else $error("evaluation continued after append");

    // A new result only appears at the end of an evaluation.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || i_m_axis_tready) ##1 r_out_valid
            |-> $past(r_state == psd_pkg::ST_EVAL) && $past(r_last))
        else $error("result without a final element");

endmodule

>>> test/tb_positive_subarray_sum_detector.sv
// Self-checking testbench for the positive subarray sum detector with a built-in window predictor.
module tb_positive_subarray_sum_detector;

    localparam int unsigned VALUE_W      = psd_pkg::VALUE_W;
    localparam int unsigned SUM_W        = psd_pkg::SUM_W;
    localparam int unsigned WINDOW_DEPTH = 1024;
    localparam int unsigned AW           = $clog2(WINDOW_DEPTH);
    localparam int unsigned CLK_HALF     = 6;
    // Settle time allows for an eviction of every stored entry plus the accept and evaluate steps.
    localparam int unsigned SETTLE_CYCLES = 2 * WINDOW_DEPTH + 16;
    localparam int unsigned RUN_LIMIT     = 1_000_000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
    localparam logic [AW-1:0]      LAST_IDX  = AW'(WINDOW_DEPTH - 1);

    typedef struct packed {
        logic found;
        logic window_overflow;
    } t_verdict;

    // Clock, reset and block inputs, all known from time zero.
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_valid     = 1'b0;
    logic [VALUE_W-1:0] i_cfg_data      = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic [31:0]        i_s_axis_tdata  = '0;
    logic               i_s_axis_tlast  = 1'b0;
    logic               i_m_axis_tready = 1'b0;
    logic               o_cfg_ready;
    logic               o_s_axis_tready;
    logic               o_m_axis_tvalid;
    logic [7:0]         o_m_axis_tdata;
    logic               o_m_axis_tuser;

    // Idle rates in percent and the long receiver hold-off flag.
    int unsigned send_idle_pct = 14;
    int unsigned recv_idle_pct = 65;
    logic        recv_hold     = 1'b0;

    // Window model: element store, indexes, running sum and sticky flags.
    logic [VALUE_W-1:0] win_store [WINDOW_DEPTH];
    logic [AW-1:0]      win_head   = '0;
    logic [AW-1:0]      win_tail   = '0;
    int unsigned        win_count  = 0;
    logic [SUM_W-1:0]   win_sum    = '0;
    logic               win_found  = 1'b0;
    logic               win_ovf    = 1'b0;
    logic [VALUE_W-1:0] target_mirror = VALUE_W'(1);

    t_verdict    pending_verdicts [$];
    int unsigned fail_count     = 0;
    int unsigned elements_sent  = 0;
    int unsigned verdicts_seen  = 0;
    int unsigned found_seen     = 0;
    int unsigned overflow_seen  = 0;

    positive_subarray_sum_detector #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),   // [30:0] value, [31] zero fill
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),   // [0] found, [7:1] zero fill
        .o_m_axis_tuser (o_m_axis_tuser)    // [0] window_overflow
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Evict the oldest window entry and take it out of the running sum.
    task automatic evict_oldest();
        win_sum   = win_sum - {1'b0, win_store[win_head]};
        win_head  = (win_head == LAST_IDX) ? '0 : win_head + AW'(1);
        win_count = win_count - 1;
    endtask

    // Advance the window by one accepted element; a last element queues the verdict.
    task automatic advance_window(input logic [VALUE_W-1:0] value, input logic last);
        logic [SUM_W-1:0] value_ext;
        logic [SUM_W-1:0] target_ext;
        value_ext  = {1'b0, value};
        target_ext = {1'b0, target_mirror};
        while (win_count > 0 && win_sum + value_ext > target_ext)
            evict_oldest();
        if (win_sum + value_ext <= target_ext) begin
            if (win_count >= WINDOW_DEPTH) begin
                win_ovf = 1'b1;
                evict_oldest();
            end
            win_store[win_tail] = value;
            win_tail  = (win_tail == LAST_IDX) ? '0 : win_tail + AW'(1);
            win_count = win_count + 1;
            win_sum   = win_sum + value_ext;
        end
        if (win_sum == target_ext)
            win_found = 1'b1;
        if (last) begin
            pending_verdicts.push_back('{found: win_found, window_overflow: win_ovf});
            win_head  = '0;
            win_tail  = '0;
            win_count = 0;
            win_sum   = '0;
            win_found = 1'b0;
            win_ovf   = 1'b0;
        end
    endtask

    // Offer one element after a random idle gap and wait for its transfer.
    task automatic send_element(input logic [VALUE_W-1:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, value};
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        elements_sent++;
        advance_window(value, last);
    endtask

    // Stop offering, wait for every queued verdict, then let the block settle.
    task automatic wait_for_drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write target_sum over the configuration channel; the block is idle here.
    task automatic write_target(input logic [VALUE_W-1:0] target);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= target;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid   <= 1'b0;
        target_mirror = target;
    endtask

    // Hold the receiver off for a fixed number of cycles in a process of its own.
    task automatic hold_receiver(input int unsigned cycles);
        fork
            begin
                recv_hold <= 1'b1;
                repeat (cycles) @(posedge i_clk);
                recv_hold <= 1'b0;
            end
        join_none
    endtask

    // Pick an element relative to the target so that exact matches happen often.
    function automatic logic [VALUE_W-1:0] pick_element(input logic [VALUE_W-1:0] target);
        int unsigned        sel;
        logic [VALUE_W-1:0] span;
        sel  = $urandom_range(99);
        span = (target > 3) ? target / 3 : VALUE_W'(1);
        if (sel < 4)
            return '0;
        else if (sel < 10)
            return VALUE_W'($urandom());
        else if (sel < 14)
            return target;
        else
            return VALUE_W'($urandom_range(span, 1));
    endfunction

    // Result side: check each transfer against the oldest verdict and drive tready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: found=%0b window_overflow=%0b",
                       o_m_axis_tdata[0], o_m_axis_tuser);
                fail_count++;
            end else begin
                t_verdict want;
                want = pending_verdicts.pop_front();
                if (o_m_axis_tdata[0] !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, o_m_axis_tdata[0]);
                    fail_count++;
                end
                if (o_m_axis_tuser !== want.window_overflow) begin
                    $error("window_overflow: expected %0b, got %0b",
                           want.window_overflow, o_m_axis_tuser);
                    fail_count++;
                end
                if (want.found)
                    found_seen++;
                if (want.window_overflow)
                    overflow_seen++;
            end
        end
        i_m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Hand-picked sequences: extremes, lone oversized elements, zeros and a target change.
    task automatic test_directed_cases();
        // Reset target of one.
        send_element(1, 1'b1);
        send_element(2, 1'b1);
        wait_for_drain();
        write_target(10);
        send_element(3, 1'b0);
        send_element(4, 1'b0);
        send_element(3, 1'b1);
        send_element(6, 1'b0);
        send_element(5, 1'b0);
        send_element(4, 1'b1);
        // A zero element followed by an exact match.
        wait_for_drain();
        write_target(5);
        send_element(0, 1'b0);
        send_element(5, 1'b1);
        // Largest target reached by one element and by two halves.
        wait_for_drain();
        write_target(VALUE_MAX);
        send_element(VALUE_MAX, 1'b1);
        send_element(31'h4000_0000, 1'b0);
        send_element(31'h3FFF_FFFF, 1'b1);
        // Zero target: a zero element matches.
        wait_for_drain();
        write_target(0);
        send_element(0, 1'b1);
        send_element(7, 1'b1);
        // Target lowered in the middle of a sequence; the window is kept.
        wait_for_drain();
        write_target(10);
        send_element(4, 1'b0);
        send_element(4, 1'b0);
        wait_for_drain();
        write_target(5);
        send_element(1, 1'b1);
        wait_for_drain();
    endtask

    // Run one sequence past the window depth so entries wrap and evict, then end it with
    // a full-scale element that empties the whole full window.
    task automatic test_window_overflow();
        write_target(VALUE_MAX);
        for (int unsigned i = 0; i < WINDOW_DEPTH + 12; i++)
            send_element(VALUE_W'($urandom_range(1 << 20, 1)), 1'b0);
        send_element(VALUE_MAX, 1'b1);
        wait_for_drain();
    endtask

    // Long receiver hold-off while short sequences keep coming, so the input stalls.
    task automatic test_output_backpressure();
        write_target(20);
        hold_receiver(400);
        for (int unsigned s = 0; s < 40; s++) begin
            if ($urandom_range(1))
                send_element(pick_element(target_mirror), 1'b0);
            send_element(pick_element(target_mirror), 1'b1);
        end
        wait_for_drain();
    endtask

    // Random sequences over several targets and the three idle regimes.
    task automatic test_random_sequences();
        logic [VALUE_W-1:0] target;
        int unsigned        phase_items;
        int unsigned        seq_len;
        for (int unsigned phase = 0; phase < 12; phase++) begin
            if (phase == 4) begin
                send_idle_pct = 65;
                recv_idle_pct = 14;
            end else if (phase == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0:       target = VALUE_MAX;
                1:       target = 1;
                2:       target = 0;
                default: target = $urandom_range(1) ? VALUE_W'($urandom_range(2000, 2))
                                                    : VALUE_W'($urandom());
            endcase
            write_target(target);
            phase_items = 0;
            while (phase_items < 36) begin
                seq_len = ($urandom_range(9) == 0) ? $urandom_range(60, 25)
                                                   : $urandom_range(24, 1);
                for (int unsigned i = 0; i < seq_len; i++)
                    send_element(pick_element(target), i == seq_len - 1);
                phase_items += seq_len;
            end
            wait_for_drain();
        end
    endtask

    // Run limit in case the block hangs.
    initial begin
        #(2 * CLK_HALF * RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence: reset, then each test in turn, then the verdict.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_window_overflow();
        test_output_backpressure();
        test_random_sequences();
        wait_for_drain();
        $display("Sent %0d elements; %0d results checked (%0d found, %0d with window overflow).",
                 elements_sent, verdicts_seen, found_seen, overflow_seen);
        $display("Targets from zero to full scale, window wrap and overflow, long output stall.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/psd_pkg.sv
rtl/psd_ram.sv
rtl/positive_subarray_sum_detector.sv
test/tb_positive_subarray_sum_detector.sv
